// ----- rtl/core/qta_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tagged quota accounting package
// Beat layouts, opcodes, register indexes and shared control types.
// ----------------------------------------------------------------------------
package qta_pkg;

    // Field widths fixed by the beat layouts
    localparam int FIELD_BITS    = 48;
    localparam int OP_BITS       = 2;
    localparam int TAG_BITS      = 2;
    localparam int IN_DATA_BITS  = 104;
    localparam int OUT_DATA_BITS = 200;
    localparam int CFG_IDX_BITS  = 3;

    // Input beat field offsets
    localparam int IN_OP_LSB   = 0;
    localparam int IN_TAG_LSB  = 2;
    localparam int IN_AMT_LSB  = 4;
    localparam int IN_NAMT_LSB = 52;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_BITS-1:0] REG_GLOBAL_LIMIT = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_TAG0_LIMIT   = 3'd1;

    // Request opcodes
    typedef enum logic [OP_BITS-1:0] {
        OP_ALLOC  = 2'd0,
        OP_FREE   = 2'd1,
        OP_RESIZE = 2'd2,
        OP_QUERY  = 2'd3
    } t_op;

    // Counter action after opcode decode
    typedef enum logic [1:0] {
        ACT_CHARGE  = 2'd0,
        ACT_RELEASE = 2'd1,
        ACT_CHECK   = 2'd2
    } t_act;

    // Outcome of one update step
    typedef struct packed {
        logic ok;
        logic pressure;
        logic commit;
    } t_verdict;

endpackage

// ----- rtl/core/qta_mem.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Per-tag counter memory
// Single write port, single registered read port; an entry not yet written
// since reset reads as zero.
// ----------------------------------------------------------------------------
module qta_mem #(
    parameter int DEPTH = 4,
    parameter int AW    = 2,
    parameter int DW    = 96
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [DW-1:0] o_rd_data,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [DW-1:0] i_wr_data
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0] r_vld;
    logic [DW-1:0] r_rd_data;
    logic          r_rd_vld;

    // Write the array
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Track written entries; reset clears them all at once
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_wr_en) begin
            r_vld[i_wr_addr] <= 1'b1;
        end
    end

    // Registered read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else if (i_rd_en) begin
            r_rd_vld <= r_vld[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule

// ----- rtl/core/qta_arith.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quota update arithmetic
// Limit checks, saturating charge and release, and peak tracking for one
// tag and for the total.
// ----------------------------------------------------------------------------
module qta_arith #(
    parameter int COUNT_BITS = 48
) (
    input  qta_pkg::t_act                  i_act,
    input  logic                           i_tag_inr,
    input  logic [qta_pkg::FIELD_BITS-1:0] i_delta,
    input  logic [qta_pkg::FIELD_BITS-1:0] i_tag_limit,
    input  logic [qta_pkg::FIELD_BITS-1:0] i_glob_limit,
    input  logic [COUNT_BITS-1:0]          i_tag_use,
    input  logic [COUNT_BITS-1:0]          i_tag_peak,
    input  logic [COUNT_BITS-1:0]          i_all_use,
    input  logic [COUNT_BITS-1:0]          i_all_peak,
    output qta_pkg::t_verdict              o_verdict,
    output logic [COUNT_BITS-1:0]          o_tag_use,
    output logic [COUNT_BITS-1:0]          o_tag_peak,
    output logic [COUNT_BITS-1:0]          o_all_use,
    output logic [COUNT_BITS-1:0]          o_all_peak
);

    localparam int FB = qta_pkg::FIELD_BITS;
    localparam int WB = ((COUNT_BITS > FB) ? COUNT_BITS : FB) + 1;

    logic [WB-1:0] w_delta;
    logic [WB-1:0] w_tag_use;
    logic [WB-1:0] w_all_use;
    logic [WB-1:0] w_cnt_max;
    logic [WB-1:0] w_tag_sum;
    logic [WB-1:0] w_all_sum;
    logic [WB-1:0] w_tag_diff;
    logic [WB-1:0] w_all_diff;
    logic          w_fits;
    logic [COUNT_BITS-1:0] w_tag_add;
    logic [COUNT_BITS-1:0] w_all_add;
    logic [COUNT_BITS-1:0] w_tag_sub;
    logic [COUNT_BITS-1:0] w_all_sub;

    // Widen operands so sums never wrap
    assign w_delta   = WB'(i_delta);
    assign w_tag_use = WB'(i_tag_use);
    assign w_all_use = WB'(i_all_use);
    assign w_cnt_max = WB'({COUNT_BITS{1'b1}});
    assign w_tag_sum = w_tag_use + w_delta;
    assign w_all_sum = w_all_use + w_delta;
    assign w_tag_diff = w_tag_use - w_delta;
    assign w_all_diff = w_all_use - w_delta;

    // Fit test: a zero limit never rejects
    assign w_fits = ((i_tag_limit == '0) || (w_tag_sum <= WB'(i_tag_limit))) &&
                    ((i_glob_limit == '0) || (w_all_sum <= WB'(i_glob_limit)));

    // Saturating add at the largest count, saturating subtract at zero
    assign w_tag_add = (w_tag_sum > w_cnt_max) ? w_cnt_max[COUNT_BITS-1:0]
                                               : w_tag_sum[COUNT_BITS-1:0];
    assign w_all_add = (w_all_sum > w_cnt_max) ? w_cnt_max[COUNT_BITS-1:0]
                                               : w_all_sum[COUNT_BITS-1:0];
    assign w_tag_sub = (w_delta >= w_tag_use) ? '0 : w_tag_diff[COUNT_BITS-1:0];
    assign w_all_sub = (w_delta >= w_all_use) ? '0 : w_all_diff[COUNT_BITS-1:0];

    // Select the new counters and the outcome
    always_comb begin
        o_verdict  = '0;
        o_tag_use  = i_tag_use;
        o_tag_peak = i_tag_peak;
        o_all_use  = i_all_use;
        o_all_peak = i_all_peak;
        if (!i_tag_inr) begin
            o_tag_use  = '0;
            o_tag_peak = '0;
        end else begin
            case (i_act)
                qta_pkg::ACT_CHARGE: begin
                    if (w_fits) begin
                        o_verdict.ok     = 1'b1;
                        o_verdict.commit = 1'b1;
                        o_tag_use  = w_tag_add;
                        o_all_use  = w_all_add;
                        o_tag_peak = (w_tag_add > i_tag_peak) ? w_tag_add : i_tag_peak;
                        o_all_peak = (w_all_add > i_all_peak) ? w_all_add : i_all_peak;
                    end else begin
                        o_verdict.pressure = 1'b1;
                    end
                end
                qta_pkg::ACT_RELEASE: begin
                    o_verdict.ok     = 1'b1;
                    o_verdict.commit = 1'b1;
                    o_tag_use = w_tag_sub;
                    o_all_use = w_all_sub;
                end
                qta_pkg::ACT_CHECK: begin
                    o_verdict.ok = w_fits;
                end
                default: begin
                    o_verdict = '0;
                end
            endcase
        end
    end

endmodule

// ----- rtl/core/tagged_quota_accounting.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tagged quota accounting
// Per-tag and global byte quota admission with usage and peak counters.
//
//   Channel   Dir  Handshake                      Payload
//   s_axis    in   s_axis_tvalid / s_axis_tready  op, tag, amount, new_amount
//   m_axis    out  m_axis_tvalid / m_axis_tready  ok, pressure, four counts
//   cfg       in   i_cfg_we                       i_cfg_idx, i_cfg_wdata
//
// Each request passes through the counter memory read, then the update and
// write-back; the next beat is taken in the cycle after the update, so the
// read-modify-write of the counter memory keeps one request in flight. Reset
// is synchronous and clears limits, totals and the memory's entry valid bits
// at once; there is no clearing pass. While a result waits on m_axis, a
// request in the update stage holds there and s_axis_tready stays low.
// ----------------------------------------------------------------------------
module tagged_quota_accounting #(
    parameter int NUM_TAGS   = 4,
    parameter int COUNT_BITS = 48
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // op[1:0], tag[3:2], amount[51:4], new_amount[99:52], zero pad
    input  logic [qta_pkg::IN_DATA_BITS-1:0]    s_axis_tdata,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // ok[0], pressure[1], tag_in_use[49:2], tag_high_mark[97:50],
    // all_in_use[145:98], all_high_mark[193:146], zero pad
    output logic [qta_pkg::OUT_DATA_BITS-1:0]   m_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    input  logic                                i_cfg_we,
    input  logic [qta_pkg::CFG_IDX_BITS-1:0]    i_cfg_idx,
    input  logic [qta_pkg::FIELD_BITS-1:0]      i_cfg_wdata
);

    localparam int FB = qta_pkg::FIELD_BITS;
    localparam int CB = COUNT_BITS;
    localparam int TW = (NUM_TAGS > 1) ? $clog2(NUM_TAGS) : 1;
    localparam int PAD_BITS = qta_pkg::OUT_DATA_BITS - 2 - 4 * FB;
    localparam int CFG_IDX_OFF_BITS = qta_pkg::CFG_IDX_BITS;

    // Limits
    logic [FB-1:0] r_glob_limit;
    logic [FB-1:0] r_tag_limit [NUM_TAGS];

    // Update stage
    logic             r_s1_vld, n_s1_vld;
    qta_pkg::t_act    r_s1_act, n_s1_act;
    logic [FB-1:0]    r_s1_delta, n_s1_delta;
    logic [TW-1:0]    r_s1_tag, n_s1_tag;
    logic             r_s1_inr, n_s1_inr;

    // Totals
    logic [CB-1:0]    r_all_use;
    logic [CB-1:0]    r_all_peak;

    // Output register
    logic             r_out_vld, n_out_vld;
    logic [qta_pkg::OUT_DATA_BITS-1:0] r_out_data;

    // Decode and datapath wires
    qta_pkg::t_op     w_op;
    logic [qta_pkg::TAG_BITS-1:0] w_tag;
    logic [FB-1:0]    w_amt;
    logic [FB-1:0]    w_namt;
    logic             w_in_fire;
    logic             w_s1_fire;
    logic             w_tag_inr;
    logic [2*CB-1:0]  w_rd_data;
    logic [2*CB-1:0]  w_wr_data;
    logic [CB-1:0]    w_tag_use, w_tag_peak, w_all_use, w_all_peak;
    qta_pkg::t_verdict w_verdict;
    logic [CFG_IDX_OFF_BITS-1:0] w_cfg_off;

    // Unpack the input beat
    assign w_op   = qta_pkg::t_op'(s_axis_tdata[qta_pkg::IN_OP_LSB +: qta_pkg::OP_BITS]);
    assign w_tag  = s_axis_tdata[qta_pkg::IN_TAG_LSB +: qta_pkg::TAG_BITS];
    assign w_amt  = s_axis_tdata[qta_pkg::IN_AMT_LSB +: FB];
    assign w_namt = s_axis_tdata[qta_pkg::IN_NAMT_LSB +: FB];
    assign w_tag_inr = ({1'b0, w_tag} < 3'(NUM_TAGS));

    // Handshakes: one item in flight, update waits for a free output register
    assign s_axis_tready = !r_s1_vld;
    assign w_in_fire     = s_axis_tvalid && s_axis_tready;
    assign w_s1_fire     = r_s1_vld && (!r_out_vld || m_axis_tready);

    // Configuration writes
    assign w_cfg_off = i_cfg_idx - qta_pkg::REG_TAG0_LIMIT;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_glob_limit <= '0;
            for (int i = 0; i < NUM_TAGS; i++) begin
                r_tag_limit[i] <= '0;
            end
        end else if (i_cfg_we) begin
            if (i_cfg_idx == qta_pkg::REG_GLOBAL_LIMIT) begin
                r_glob_limit <= i_cfg_wdata;
            end else if ((i_cfg_idx >= qta_pkg::REG_TAG0_LIMIT) &&
                         (w_cfg_off < CFG_IDX_OFF_BITS'(NUM_TAGS))) begin
                r_tag_limit[w_cfg_off[TW-1:0]] <= i_cfg_wdata;
            end
        end
    end

    // Decode the opcode into an action and a byte delta
    always_comb begin
        n_s1_act   = r_s1_act;
        n_s1_delta = r_s1_delta;
        n_s1_tag   = r_s1_tag;
        n_s1_inr   = r_s1_inr;
        if (w_in_fire) begin
            n_s1_tag = w_tag_inr ? w_tag[TW-1:0] : '0;
            n_s1_inr = w_tag_inr;
            case (w_op)
                qta_pkg::OP_ALLOC: begin
                    n_s1_act   = qta_pkg::ACT_CHARGE;
                    n_s1_delta = w_amt;
                end
                qta_pkg::OP_FREE: begin
                    n_s1_act   = qta_pkg::ACT_RELEASE;
                    n_s1_delta = w_amt;
                end
                qta_pkg::OP_RESIZE: begin
                    if (w_namt > w_amt) begin
                        n_s1_act   = qta_pkg::ACT_CHARGE;
                        n_s1_delta = w_namt - w_amt;
                    end else begin
                        n_s1_act   = qta_pkg::ACT_RELEASE;
                        n_s1_delta = w_amt - w_namt;
                    end
                end
                qta_pkg::OP_QUERY: begin
                    n_s1_act   = qta_pkg::ACT_CHECK;
                    n_s1_delta = w_amt;
                end
                default: begin
                    n_s1_act   = qta_pkg::ACT_CHECK;
                    n_s1_delta = w_amt;
                end
            endcase
        end
    end

    // Stage occupancy
    always_comb begin
        n_s1_vld = r_s1_vld;
        if (w_in_fire) begin
            n_s1_vld = 1'b1;
        end else if (w_s1_fire) begin
            n_s1_vld = 1'b0;
        end
    end

    always_comb begin
        n_out_vld = r_out_vld;
        if (w_s1_fire) begin
            n_out_vld = 1'b1;
        end else if (m_axis_tready) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_s1_vld  <= n_s1_vld;
            r_out_vld <= n_out_vld;
        end
    end

    // Hold the decoded request
    always_ff @(posedge i_clk) begin
        r_s1_act   <= n_s1_act;
        r_s1_delta <= n_s1_delta;
        r_s1_tag   <= n_s1_tag;
        r_s1_inr   <= n_s1_inr;
    end

    // Per-tag usage and peak, read on accept, written back on a committed update
    assign w_wr_data = {w_tag_peak, w_tag_use};

    qta_mem #(
        .DEPTH (NUM_TAGS),
        .AW    (TW),
        .DW    (2 * CB)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (w_in_fire),
        .i_rd_addr (n_s1_tag),
        .o_rd_data (w_rd_data),
        .i_wr_en   (w_s1_fire && w_verdict.commit),
        .i_wr_addr (r_s1_tag),
        .i_wr_data (w_wr_data)
    );

    qta_arith #(
        .COUNT_BITS (CB)
    ) u_arith (
        .i_act        (r_s1_act),
        .i_tag_inr    (r_s1_inr),
        .i_delta      (r_s1_delta),
        .i_tag_limit  (r_tag_limit[r_s1_tag]),
        .i_glob_limit (r_glob_limit),
        .i_tag_use    (w_rd_data[CB-1:0]),
        .i_tag_peak   (w_rd_data[2*CB-1:CB]),
        .i_all_use    (r_all_use),
        .i_all_peak   (r_all_peak),
        .o_verdict    (w_verdict),
        .o_tag_use    (w_tag_use),
        .o_tag_peak   (w_tag_peak),
        .o_all_use    (w_all_use),
        .o_all_peak   (w_all_peak)
    );

    // Advance the totals on each update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_all_use  <= '0;
            r_all_peak <= '0;
        end else if (w_s1_fire) begin
            r_all_use  <= w_all_use;
            r_all_peak <= w_all_peak;
        end
    end

    // Load the result beat
    always_ff @(posedge i_clk) begin
        if (w_s1_fire) begin
            r_out_data <= {{PAD_BITS{1'b0}},
                           FB'(w_all_peak), FB'(w_all_use),
                           FB'(w_tag_peak), FB'(w_tag_use),
                           w_verdict.pressure, w_verdict.ok};
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_data;

`ifndef SYNTH
    // Total peak never falls below total usage
    a_peak_ge_use: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_all_peak >= r_all_use)
        else $error("total peak below total usage");

    // An accepted beat occupies the update stage next cycle
    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_fire |=> r_s1_vld)
        else $error("accepted beat lost before update");

    // Totals move only on an update
    a_totals_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_s1_fire |=> ($stable(r_all_use) && $stable(r_all_peak)))
        else $error("totals changed without an update");

    // A rejected request never reports success
    a_pressure_not_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s1_fire && w_verdict.pressure) |-> (!w_verdict.ok && !w_verdict.commit))
        else $error("pressure raised on an admitted request");
`endif

endmodule

// ----- tb/sv/tagged_quota_accounting_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tagged quota accounting testbench
// Drives allocate, free, resize and query beats through the request stream
// under several sets of global and per-tag limits, and scores every response
// beat against a cycle-free quota model kept in step with the accepted beats.
// Both stream sides idle in random bursts, except in the last phase.
// ----------------------------------------------------------------------------
module tagged_quota_accounting_tb;

    import qta_pkg::*;

    localparam int          NUM_TAGS  = 4;
    localparam logic [47:0] COUNT_MAX = 48'hFFFF_FFFF_FFFF;

    // Kinds of limit setting used by the random phases
    typedef enum int {
        LIM_OPEN,
        LIM_TIGHT,
        LIM_EDGE,
        LIM_WIDE
    } limit_kind_t;

    typedef struct {
        t_op         op;
        logic [1:0]  tag;
        logic [47:0] amount;
        logic [47:0] new_amount;
    } quota_req_t;

    typedef struct {
        logic        ok;
        logic        pressure;
        logic [47:0] tag_used;
        logic [47:0] tag_peak;
        logic [47:0] all_used;
        logic [47:0] all_peak;
    } quota_res_t;

    logic                      i_clk         = 1'b0;
    logic                      i_rst_n       = 1'b0;
    logic [IN_DATA_BITS-1:0]   s_axis_tdata  = '0;
    logic                      s_axis_tvalid = 1'b0;
    logic                      s_axis_tready;
    logic [OUT_DATA_BITS-1:0]  m_axis_tdata;
    logic                      m_axis_tvalid;
    logic                      m_axis_tready = 1'b0;
    logic                      i_cfg_we      = 1'b0;
    logic [CFG_IDX_BITS-1:0]   i_cfg_idx     = '0;
    logic [FIELD_BITS-1:0]     i_cfg_wdata   = '0;

    // Quota model state
    logic [47:0] limit_global;
    logic [47:0] limit_tag  [NUM_TAGS];
    logic [47:0] tag_usage  [NUM_TAGS];
    logic [47:0] tag_peak   [NUM_TAGS];
    logic [47:0] usage_total;
    logic [47:0] peak_total;

    // Stimulus and scoring
    quota_req_t  request_q[$];
    quota_res_t  verdict_q[$];
    quota_req_t  cur_req;
    logic [47:0] held_size  [NUM_TAGS];
    int unsigned amt_span   = 1000;
    bit          idle_on    = 1'b1;
    bit          beat_taken = 1'b0;
    int          src_gap    = 0;
    int          sink_gap   = 0;
    int          n_issued   = 0;
    int          n_accepted = 0;
    int          n_checked  = 0;
    int          n_errors   = 0;
    int          n_rejects  = 0;
    int          n_settings = 0;

    tagged_quota_accounting #(
        .NUM_TAGS   (NUM_TAGS),
        .COUNT_BITS (48)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always #1 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Quota model
    // ------------------------------------------------------------------
    function automatic logic [47:0] sat_add(logic [47:0] a, logic [47:0] b);
        logic [48:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[48] ? COUNT_MAX : sum[47:0];
    endfunction

    function automatic logic [47:0] sat_sub(logic [47:0] a, logic [47:0] b);
        return (b >= a) ? 48'd0 : a - b;
    endfunction

    // Zero limit means unlimited; compare in 49 bits so the sum cannot wrap
    function automatic logic under_limit(logic [47:0] used, logic [47:0] extra,
                                         logic [47:0] lim);
        if (lim == 48'd0)
            return 1'b1;
        return ({1'b0, used} + {1'b0, extra}) <= {1'b0, lim};
    endfunction

    function automatic logic room_for(logic [1:0] tag, logic [47:0] extra);
        return under_limit(tag_usage[tag], extra, limit_tag[tag]) &&
               under_limit(usage_total, extra, limit_global);
    endfunction

    function automatic void add_bytes(logic [1:0] tag, logic [47:0] extra);
        tag_usage[tag] = sat_add(tag_usage[tag], extra);
        usage_total    = sat_add(usage_total, extra);
        if (tag_usage[tag] > tag_peak[tag])
            tag_peak[tag] = tag_usage[tag];
        if (usage_total > peak_total)
            peak_total = usage_total;
    endfunction

    function automatic void drop_bytes(logic [1:0] tag, logic [47:0] less);
        tag_usage[tag] = sat_sub(tag_usage[tag], less);
        usage_total    = sat_sub(usage_total, less);
    endfunction

    // Apply one accepted request to the model and return the response due
    function automatic quota_res_t account_request(quota_req_t r);
        quota_res_t  res;
        logic        fits;
        res.ok       = 1'b1;
        res.pressure = 1'b0;
        case (r.op)
            OP_ALLOC: begin
                fits = room_for(r.tag, r.amount);
                if (fits)
                    add_bytes(r.tag, r.amount);
                res.ok       = fits;
                res.pressure = !fits;
            end
            OP_FREE: begin
                drop_bytes(r.tag, r.amount);
            end
            OP_RESIZE: begin
                if (r.new_amount > r.amount) begin
                    fits = room_for(r.tag, r.new_amount - r.amount);
                    if (fits)
                        add_bytes(r.tag, r.new_amount - r.amount);
                    res.ok       = fits;
                    res.pressure = !fits;
                end else begin
                    drop_bytes(r.tag, r.amount - r.new_amount);
                end
            end
            default: begin
                res.ok = room_for(r.tag, r.amount);
            end
        endcase
        res.tag_used = tag_usage[r.tag];
        res.tag_peak = tag_peak[r.tag];
        res.all_used = usage_total;
        res.all_peak = peak_total;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic logic [47:0] draw_count();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            return 48'($urandom_range(0, amt_span));
        else if (pick < 75)
            return 48'({$urandom, $urandom});
        else if (pick < 85)
            return COUNT_MAX - 48'($urandom_range(0, 15));
        return 48'($urandom_range(0, 2));
    endfunction

    // Mostly alloc/resize/free chains on the last size per tag, plus noise
    function automatic quota_req_t make_request();
        quota_req_t  r;
        int unsigned pick;
        r.tag        = 2'($urandom_range(0, NUM_TAGS - 1));
        r.amount     = draw_count();
        r.new_amount = draw_count();
        pick         = $urandom_range(0, 99);
        if (pick < 35) begin
            r.op = OP_ALLOC;
            held_size[r.tag] = r.amount;
        end else if (pick < 58) begin
            r.op = OP_RESIZE;
            if (pick < 52)
                r.amount = held_size[r.tag];
            if ($urandom_range(0, 7) == 0)
                r.new_amount = r.amount;
            held_size[r.tag] = r.new_amount;
        end else if (pick < 80) begin
            r.op = OP_FREE;
            if (pick < 74)
                r.amount = held_size[r.tag];
            held_size[r.tag] = '0;
        end else begin
            r.op = OP_QUERY;
        end
        return r;
    endfunction

    task automatic queue_req(t_op op, logic [1:0] tag, logic [47:0] amount,
                             logic [47:0] new_amount);
        quota_req_t r;
        r.op         = op;
        r.tag        = tag;
        r.amount     = amount;
        r.new_amount = new_amount;
        request_q = {request_q, r};
        n_issued++;
    endtask

    // Register write; the block is idle so the model follows at once
    task automatic write_limit(logic [CFG_IDX_BITS-1:0] idx, logic [47:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= value;
        if (idx == REG_GLOBAL_LIMIT)
            limit_global = value;
        else if (idx >= REG_TAG0_LIMIT && idx < REG_TAG0_LIMIT + NUM_TAGS)
            limit_tag[idx - REG_TAG0_LIMIT] = value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Hold the sender back until every response is in
    task automatic drain();
        do
            @(negedge i_clk);
        while (n_accepted != n_issued || n_checked != n_accepted);
    endtask

    task automatic set_limits(limit_kind_t kind);
        logic [47:0] vals [NUM_TAGS + 1];
        for (int i = 0; i <= NUM_TAGS; i++) begin
            case (kind)
                LIM_OPEN:  vals[i] = '0;
                LIM_TIGHT: vals[i] = 48'($urandom_range(1, 2500));
                LIM_WIDE:  vals[i] = 48'({$urandom, $urandom});
                default:   vals[i] = 48'($urandom_range(1, 4000));
            endcase
        end
        case (kind)
            LIM_TIGHT: begin
                vals[0] = 48'($urandom_range(1, 6000));
                vals[1 + $urandom_range(0, NUM_TAGS - 1)] = '0;
                amt_span = 1500;
            end
            LIM_EDGE: begin
                vals[0] = COUNT_MAX;
                vals[1] = COUNT_MAX;
                vals[2] = 48'd1;
                vals[3] = '0;
                amt_span = 3000;
            end
            LIM_WIDE: amt_span = 32'hFFFF_FFFF;
            default:  amt_span = 100000;
        endcase
        for (int i = 0; i <= NUM_TAGS; i++)
            write_limit(REG_GLOBAL_LIMIT + CFG_IDX_BITS'(i), vals[i]);
        // an index past the last tag must leave every limit alone
        if (kind == LIM_EDGE)
            write_limit(REG_TAG0_LIMIT + CFG_IDX_BITS'(NUM_TAGS), 48'd7);
        n_settings++;
    endtask

    // ------------------------------------------------------------------
    // Request driver
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || beat_taken) begin
            beat_taken = 1'b0;
            if (src_gap == 0 && idle_on && $urandom_range(0, 7) == 0)
                src_gap = $urandom_range(1, 9);
            if (src_gap > 0) begin
                src_gap--;
                s_axis_tvalid <= 1'b0;
            end else if (request_q.size() > 0) begin
                cur_req = request_q.pop_front();
                s_axis_tdata  <= {4'b0, cur_req.new_amount, cur_req.amount,
                                  cur_req.tag, cur_req.op};
                s_axis_tvalid <= 1'b1;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Response back-pressure in random bursts
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (sink_gap == 0 && idle_on && $urandom_range(0, 7) == 0)
                sink_gap = $urandom_range(1, 9);
            if (sink_gap > 0) begin
                sink_gap--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor and scoreboard
    // ------------------------------------------------------------------
    task automatic check_field(string name, logic [47:0] want, logic [47:0] got);
        if (want !== got) begin
            n_errors++;
            if (n_errors <= 10)
                $display("mismatch on response %0d, %s: expected 0x%0h, got 0x%0h",
                         n_checked, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        quota_res_t want;
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            verdict_q = {verdict_q, account_request(cur_req)};
            beat_taken = 1'b1;
            n_accepted++;
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (verdict_q.size() == 0) begin
                n_errors++;
                if (n_errors <= 10)
                    $display("response beat with none outstanding: 0x%0h", m_axis_tdata);
            end else begin
                want = verdict_q.pop_front();
                check_field("ok", 48'(want.ok), 48'(m_axis_tdata[0]));
                check_field("pressure", 48'(want.pressure), 48'(m_axis_tdata[1]));
                check_field("tag_in_use", want.tag_used, m_axis_tdata[49:2]);
                check_field("tag_high_mark", want.tag_peak, m_axis_tdata[97:50]);
                check_field("all_in_use", want.all_used, m_axis_tdata[145:98]);
                check_field("all_high_mark", want.all_peak, m_axis_tdata[193:146]);
                if (want.pressure)
                    n_rejects++;
                n_checked++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        limit_global = '0;
        usage_total  = '0;
        peak_total   = '0;
        for (int i = 0; i < NUM_TAGS; i++) begin
            limit_tag[i] = '0;
            tag_usage[i] = '0;
            tag_peak[i]  = '0;
            held_size[i] = '0;
        end
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Unlimited: zero amount, saturation of usage and total, frees past zero
        queue_req(OP_ALLOC,  2'd0, 48'd0, COUNT_MAX);
        queue_req(OP_ALLOC,  2'd1, COUNT_MAX, 48'd0);
        queue_req(OP_ALLOC,  2'd2, 48'd5, 48'd0);
        queue_req(OP_QUERY,  2'd3, COUNT_MAX, COUNT_MAX);
        queue_req(OP_FREE,   2'd1, COUNT_MAX, 48'd0);
        queue_req(OP_FREE,   2'd2, 48'd100, 48'd0);
        queue_req(OP_RESIZE, 2'd0, 48'd10, 48'd10);
        queue_req(OP_RESIZE, 2'd0, 48'd0, COUNT_MAX);
        queue_req(OP_RESIZE, 2'd0, COUNT_MAX, 48'd0);
        queue_req(OP_RESIZE, 2'd3, 48'd3, 48'd1);
        drain();

        // Tight limits: exact fit, tag and global rejects, grow and shrink
        write_limit(REG_GLOBAL_LIMIT, 48'd1000);
        write_limit(REG_TAG0_LIMIT, 48'd100);
        write_limit(REG_TAG0_LIMIT + 3'd1, COUNT_MAX);
        write_limit(REG_TAG0_LIMIT + 3'd2, 48'd1);
        write_limit(REG_TAG0_LIMIT + 3'd3, 48'd0);
        n_settings += 2;
        queue_req(OP_ALLOC,  2'd0, 48'd100, 48'd0);
        queue_req(OP_ALLOC,  2'd0, 48'd1, 48'd0);
        queue_req(OP_QUERY,  2'd0, 48'd0, 48'd0);
        queue_req(OP_QUERY,  2'd0, 48'd1, 48'd0);
        queue_req(OP_ALLOC,  2'd2, 48'd2, 48'd0);
        queue_req(OP_ALLOC,  2'd3, 48'd900, 48'd0);
        queue_req(OP_ALLOC,  2'd3, 48'd1, 48'd0);
        queue_req(OP_RESIZE, 2'd0, 48'd50, 48'd51);
        queue_req(OP_RESIZE, 2'd0, 48'd60, 48'd10);
        queue_req(OP_ALLOC,  2'd1, COUNT_MAX, 48'd0);
        queue_req(OP_FREE,   2'd3, COUNT_MAX, 48'd0);
        drain();

        // Random phases, each under a fresh limit setting
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0:       set_limits(LIM_OPEN);
                2:       set_limits(LIM_EDGE);
                3:       set_limits(LIM_WIDE);
                default: set_limits(LIM_TIGHT);
            endcase
            if (phase == 5)
                idle_on = 1'b0;
            for (int k = 0; k < 290; k++)
                request_q = {request_q, make_request()};
            n_issued += 290;
            drain();
        end

        // Let any stray response show up before scoring ends
        repeat (20) @(negedge i_clk);
        n_errors += verdict_q.size();
        $display("%0d responses scored over %0d limit settings, %0d rejected on quota",
                 n_checked, n_settings, n_rejects);
        if (n_errors == 0)
            $display("tagged_quota_accounting_tb: clean");
        else
            $display("tagged_quota_accounting_tb: errors");
        $finish;
    end

    // Watchdog
    initial begin
        #400000;
        $display("tagged_quota_accounting_tb: errors");
        $finish;
    end

endmodule
